// ===== rtl/core/sirs_pkg.sv =====
`timescale 1ns / 1ps
package sirs_pkg;
    localparam int MAX_SYMBOLS = 64;
    localparam int NUMBER_WIDTH = 32;
    localparam int IDX_W = 6;
    localparam int LEN_W = 7;
    localparam int CNT_W = 6;
    localparam int CODE_W = 8;
    localparam logic [CODE_W-1:0] SYM_PLUS = 8'h2B;
    localparam logic [CODE_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CONVERT = 1'b1;
    typedef logic [CODE_W-1:0] code_t;
endpackage

// ===== rtl/core/signed_integer_to_radix_symbols.sv =====
`timescale 1ns / 1ps
// Command-style converter, no output backpressure: each word sits on char_code/last
// for one cycle with valid high and the receiver cannot stall it. A load writes the
// table and busy stays low. A convert with a length outside 2..64 is dropped in
// its accept cycle. Otherwise it first scans the alphabet for plus/minus and
// duplicate symbols, one registered table read per check over all pairs, then
// divides by restoring long division, one quotient bit per cycle, and pushes each
// digit into the stack memory, then emits the optional '-' and each digit through
// the table memory. busy stays high until the last digit is emitted, or until
// the scan rejects the alphabet; invalid alphabets give no words.
module signed_integer_to_radix_symbols
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [sirs_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                         opcode,
    input  logic signed [31:0]           number,
    input  logic [sirs_pkg::IDX_W-1:0]   symbol_index,
    input  logic [7:0]                   symbol_code,
    output logic                         valid,
    output logic [7:0]                   char_code,
    output logic                         last
);
    import sirs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHKA  = 4'd1;
    localparam logic [3:0] S_CHKAW = 4'd2;
    localparam logic [3:0] S_CHKB  = 4'd3;
    localparam logic [3:0] S_CHKBW = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_SIGN  = 4'd7;
    localparam logic [3:0] S_POP   = 4'd8;
    localparam logic [3:0] S_POPW  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    code_t             alpha_mem [MAX_SYMBOLS];
    logic [IDX_W-1:0]  stack_mem [NUMBER_WIDTH];

    logic [3:0]              state_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [IDX_W-1:0]        i_reg, j_reg;
    code_t                   a_reg;
    logic [NUMBER_WIDTH-1:0] q_reg;
    logic [LEN_W-1:0]        rem_reg;
    logic [5:0]              bit_reg;
    logic [CNT_W-1:0]        depth_reg;
    logic                    neg_reg;
    logic [IDX_W-1:0]        ar_addr;
    code_t                   ar_data;
    logic [IDX_W-1:0]        st_rd;
    logic [LEN_W:0]          trial;
    logic                    trial_ge;

    assign busy = (state_reg != S_IDLE);
    assign trial = {rem_reg, q_reg[NUMBER_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, len_reg});

    always_comb
    begin
        ar_addr = i_reg;
        case (state_reg)
            S_CHKB:  ar_addr = j_reg;
            S_POPW:  ar_addr = st_rd;
            default: ar_addr = i_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && opcode == OP_LOAD)
            alpha_mem[symbol_index] <= symbol_code;
        ar_data <= alpha_mem[ar_addr];
        if (state_reg == S_PUSH)
            stack_mem[depth_reg[4:0]] <= rem_reg[IDX_W-1:0];
        st_rd <= stack_mem[depth_reg[4:0] - 5'd1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            valid     <= 1'b0;
            char_code <= '0;
            last      <= 1'b0;
            i_reg <= '0; j_reg <= '0; a_reg <= '0; q_reg <= '0; rem_reg <= '0;
            bit_reg <= '0; depth_reg <= '0; neg_reg <= 1'b0;
        end
        else
        begin
            valid <= 1'b0;
            if (cfg_we)
                len_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && opcode == OP_CONVERT)
                    begin
                        neg_reg <= number[31];
                        q_reg <= number[31] ? 32'(-number) : number;
                        i_reg <= '0;
                        depth_reg <= '0;
                        if (len_reg >= 7'd2 && len_reg <= 7'(MAX_SYMBOLS))
                            state_reg <= S_CHKA;
                    end
                end
                S_CHKA:  state_reg <= S_CHKAW;
                S_CHKAW:
                begin
                    a_reg <= ar_data;
                    j_reg <= i_reg + 6'd1;
                    if (ar_data == SYM_PLUS || ar_data == SYM_MINUS)
                        state_reg <= S_IDLE;
                    else if (7'(i_reg) + 7'd1 >= len_reg)
                    begin
                        rem_reg <= '0;
                        bit_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        state_reg <= S_CHKB;
                end
                S_CHKB:  state_reg <= S_CHKBW;
                S_CHKBW:
                begin
                    if (ar_data == a_reg)
                        state_reg <= S_IDLE;
                    else if (7'(j_reg) + 7'd1 >= len_reg)
                    begin
                        i_reg <= i_reg + 6'd1;
                        state_reg <= S_CHKA;
                    end
                    else
                    begin
                        j_reg <= j_reg + 6'd1;
                        state_reg <= S_CHKB;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg <= trial_ge ? LEN_W'(trial - {1'b0, len_reg})
                                        : LEN_W'(trial);
                    q_reg <= {q_reg[NUMBER_WIDTH-2:0], trial_ge};
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'(NUMBER_WIDTH - 1))
                        state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    depth_reg <= depth_reg + 6'd1;
                    rem_reg <= '0;
                    bit_reg <= '0;
                    if (q_reg != '0)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_SIGN;
                end
                S_SIGN:
                begin
                    if (neg_reg)
                    begin
                        valid <= 1'b1;
                        char_code <= SYM_MINUS;
                        last <= 1'b0;
                    end
                    state_reg <= S_POP;
                end
                S_POP:  state_reg <= S_POPW;
                S_POPW: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    valid <= 1'b1;
                    char_code <= ar_data;
                    last <= (depth_reg == 6'd1);
                    depth_reg <= depth_reg - 6'd1;
                    state_reg <= (depth_reg == 6'd1) ? S_IDLE : S_POP;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
